/* design/kpc_pkg.sv */
// Shared constants, types and codes of the keyed parameter cache.
`timescale 1ns / 1ps

package kpc_pkg;

    localparam int NUM_AXES = 8;
    localparam int ENTRIES  = 16;
    localparam int TOTAL    = NUM_AXES * ENTRIES;

    localparam int KEY_W   = 24;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = KEY_W + DATA_W;

    localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_AXIS_ERR = 2'd1;
    localparam logic [1:0] ST_MISS     = 2'd2;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [ENT_W-1:0]  hit_idx;
        logic [DATA_W-1:0] hit_data;
        logic              free;
        logic [ENT_W-1:0]  free_idx;
    } t_scan_res;

endpackage

/* design/keyed_parameter_cache_top.sv */
// Top level of the keyed parameter cache: handshakes, valid bits, entry store, update.
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------
// input    | i_valid / o_stall  | i_cmd, i_axis_number, i_object_index,
//          |                    | i_object_subindex, i_write_data
// output   | o_valid / i_stall  | o_status, o_read_data
//
// An in-range item is scanned in its bank, read one entry a cycle from the key/value
// RAM and checked by one comparator. An out-of-range axis skips the scan and goes
// straight to the final step.
// Reset clears the valid bits of all NUM_AXES * ENTRIES entries at once; the RAM
// contents are not cleared and are only used behind a set valid bit.
// The input is stalled while an item is at work. A waiting result holds the
// block in its final step until the output side takes it.

module keyed_parameter_cache_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_axis_number,
    input  logic [15:0]                  i_object_index,
    input  logic [7:0]                   i_object_subindex,
    input  logic [31:0]                  i_write_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [31:0]                  o_read_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_cmd;
    logic [kpc_pkg::KEY_W-1:0]       r_key;
    logic [kpc_pkg::DATA_W-1:0]      r_wdata;
    logic [kpc_pkg::ADDR_W-1:0]      r_base;
    logic                            r_axis_err;
    logic                            r_start, n_start;
    logic                            r_out_valid, n_out_valid;
    logic [1:0]                      r_status, n_status;
    logic [kpc_pkg::DATA_W-1:0]      r_rdata, n_rdata;
    logic [kpc_pkg::TOTAL-1:0]       r_valid;

    logic                            w_accept;
    logic                            w_load;
    logic                            w_wr;
    logic [kpc_pkg::ENT_W-1:0]       w_woff;
    logic [kpc_pkg::ADDR_W-1:0]      w_waddr;
    logic                            w_rd_en;
    logic [kpc_pkg::ADDR_W-1:0]      w_rd_addr;
    logic [kpc_pkg::ENTRY_W-1:0]     w_ram_rdata;
    kpc_pkg::t_scan_res              w_scan;

    assign w_accept = i_valid && (r_state == S_IDLE);
    // load the result once the output register is free or being drained
    assign w_load   = (r_state == S_FINISH) && (!r_out_valid || !i_stall);
    assign w_wr     = w_load && !r_axis_err && (r_cmd == kpc_pkg::CMD_WRITE);

    // update a match, else fill the first free entry, else replace entry 0
    always_comb begin
        if (w_scan.hit) begin
            w_woff = w_scan.hit_idx;
        end else if (w_scan.free) begin
            w_woff = w_scan.free_idx;
        end else begin
            w_woff = '0;
        end
    end
    assign w_waddr = r_base + kpc_pkg::ADDR_W'(w_woff);

    kpc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .i_key        (r_key),
        .i_base       (r_base),
        .i_slot_valid (r_valid[w_rd_addr]),
        .i_rdata      (w_ram_rdata),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .o_res        (w_scan)
    );

    kpc_ram #(
        .WIDTH (kpc_pkg::ENTRY_W),
        .DEPTH (kpc_pkg::TOTAL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_waddr),
        .i_wdata ({r_key, r_wdata}),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_rdata     = r_rdata;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_axis_number < 8'(kpc_pkg::NUM_AXES)) begin
                        n_start = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_axis_err) begin
                        n_status = kpc_pkg::ST_AXIS_ERR;
                        n_rdata  = '0;
                    end else if (r_cmd == kpc_pkg::CMD_WRITE) begin
                        n_status = kpc_pkg::ST_OK;
                        n_rdata  = '0;
                    end else if (w_scan.hit) begin
                        n_status = kpc_pkg::ST_OK;
                        n_rdata  = w_scan.hit_data;
                    end else begin
                        n_status = kpc_pkg::ST_MISS;
                        n_rdata  = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (w_wr) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
        r_status <= n_status;
        r_rdata  <= n_rdata;
        // capture the item
        if (w_accept) begin
            r_cmd      <= i_cmd;
            r_key      <= {i_object_index, i_object_subindex};
            r_wdata    <= i_write_data;
            r_base     <= kpc_pkg::ADDR_W'(int'(i_axis_number) * kpc_pkg::ENTRIES);
            r_axis_err <= !(i_axis_number < 8'(kpc_pkg::NUM_AXES));
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_read_data = r_rdata;

`ifndef SYNTH
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.done |-> (r_state == S_SCAN))
        else $error("scan done outside scan state");

    a_write_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (w_load && !r_axis_err))
        else $error("entry write without result load");

    a_axis_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_axis_err) |=>
            (o_valid && (o_status == kpc_pkg::ST_AXIS_ERR) && (o_read_data == '0)))
        else $error("axis error result malformed");

    a_start_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> ((r_state == S_SCAN) && !r_axis_err))
        else $error("scan started for rejected item");

    a_miss_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == kpc_pkg::ST_MISS)) |-> (o_read_data == '0))
        else $error("read miss with nonzero data");
`endif

endmodule

/* design/kpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/kpc_scan.sv */
// Bank scan sequencer: walks one bank through a single key comparator.
`timescale 1ns / 1ps

module kpc_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kpc_pkg::KEY_W-1:0]   i_key,
    input  logic [kpc_pkg::ADDR_W-1:0]  i_base,
    input  logic                        i_slot_valid,
    input  logic [kpc_pkg::ENTRY_W-1:0] i_rdata,
    output logic                        o_rd_en,
    output logic [kpc_pkg::ADDR_W-1:0]  o_rd_addr,
    output kpc_pkg::t_scan_res          o_res
);

    logic                             r_busy;
    logic [kpc_pkg::CNT_W-1:0]        r_rd_idx;
    logic                             r_cmp_vld;
    logic [kpc_pkg::ENT_W-1:0]        r_cmp_idx;
    logic                             r_cmp_slot;
    logic                             r_done;
    logic                             r_hit;
    logic [kpc_pkg::ENT_W-1:0]        r_hit_idx;
    logic [kpc_pkg::DATA_W-1:0]       r_hit_data;
    logic                             r_free;
    logic [kpc_pkg::ENT_W-1:0]        r_free_idx;

    logic                             w_issue;
    logic [kpc_pkg::ENT_W-1:0]        w_idx;
    logic                             w_match;

    assign w_issue = r_busy && (r_rd_idx < kpc_pkg::CNT_W'(kpc_pkg::ENTRIES));
    assign w_idx   = r_rd_idx[kpc_pkg::ENT_W-1:0];
    // the one shared comparator
    assign w_match = r_cmp_vld && r_cmp_slot
                     && (i_rdata[kpc_pkg::ENTRY_W-1:kpc_pkg::DATA_W] == i_key);

    assign o_rd_en   = w_issue;
    assign o_rd_addr = i_base + kpc_pkg::ADDR_W'(w_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_rd_idx  <= '0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            r_done    <= 1'b0;
            r_cmp_vld <= w_issue;
            if (w_issue) begin
                r_rd_idx   <= r_rd_idx + 1'b1;
                r_cmp_idx  <= w_idx;
                r_cmp_slot <= i_slot_valid;
                if (!i_slot_valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= w_idx;
                end
            end
            // keep the first match
            if (w_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_cmp_idx;
                r_hit_data <= i_rdata[kpc_pkg::DATA_W-1:0];
            end
            if (r_busy && !w_issue && !r_cmp_vld) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.hit      = r_hit;
    assign o_res.hit_idx  = r_hit_idx;
    assign o_res.hit_data = r_hit_data;
    assign o_res.free     = r_free;
    assign o_res.free_idx = r_free_idx;

endmodule

/* tb/keyed_parameter_cache_checker.sv */
// Checker for the keyed parameter cache: bank predictor and result scoreboard.
`timescale 1ns / 1ps

module keyed_parameter_cache_checker
    import kpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_cmd,
    input  logic [7:0]  i_axis_number,
    input  logic [15:0] i_object_index,
    input  logic [7:0]  i_object_subindex,
    input  logic [31:0] i_write_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_read_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_read_hits,
    output int          o_evictions
);

    logic              bank_valid [TOTAL];
    logic [KEY_W-1:0]  bank_key   [TOTAL];
    logic [DATA_W-1:0] bank_value [TOTAL];

    logic [1:0]        want_status_q [$];
    logic [DATA_W-1:0] want_data_q   [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_read_hits  = 0;
        o_evictions  = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Apply one access to the bank copy and return the result it should give.
    task automatic predict_access(input logic cmd, input logic [7:0] axis,
                                  input logic [KEY_W-1:0] key, input logic [DATA_W-1:0] data,
                                  output logic [1:0] status, output logic [DATA_W-1:0] rdata);
        int base;
        int hit;
        int free;
        int slot;
        status = ST_OK;
        rdata  = '0;
        if (axis >= NUM_AXES) begin
            status = ST_AXIS_ERR;
            return;
        end
        base = int'(axis) * ENTRIES;
        hit  = -1;
        free = -1;
        for (int e = 0; e < ENTRIES; e++) begin
            if (hit < 0 && bank_valid[base + e] && bank_key[base + e] == key) hit = e;
            if (free < 0 && !bank_valid[base + e]) free = e;
        end
        if (cmd == CMD_READ) begin
            if (hit >= 0) begin
                rdata = bank_value[base + hit];
                o_read_hits++;
            end else begin
                status = ST_MISS;
            end
        end else begin
            // matching key first, then lowest free entry, else replace entry 0
            if (hit >= 0) begin
                slot = hit;
            end else if (free >= 0) begin
                slot = free;
            end else begin
                slot = 0;
                o_evictions++;
            end
            bank_valid[base + slot] = 1'b1;
            bank_key[base + slot]   = key;
            bank_value[base + slot] = data;
        end
    endtask

    always @(posedge i_clk) begin
        logic [1:0]        st;
        logic [DATA_W-1:0] rd;
        if (!i_rst_n) begin
            for (int s = 0; s < TOTAL; s++) bank_valid[s] = 1'b0;
            want_status_q.delete();
            want_data_q.delete();
            o_pending = 0;
        end else begin
            // compare results before taking new requests
            if (i_rsp_valid && !i_rsp_stall) begin
                if (want_status_q.size() == 0) begin
                    report_mismatch("unexpected result status", 32'(i_status), 0);
                end else begin
                    st = want_status_q.pop_front();
                    rd = want_data_q.pop_front();
                    if (i_status !== st) report_mismatch("status", 32'(i_status), 32'(st));
                    if (i_read_data !== rd) report_mismatch("read_data", i_read_data, rd);
                    o_checked++;
                end
            end
            if (i_valid && !i_stall_in) begin
                predict_access(i_cmd, i_axis_number, {i_object_index, i_object_subindex},
                               i_write_data, st, rd);
                want_status_q.push_back(st);
                want_data_q.push_back(rd);
            end
            o_pending = want_status_q.size();
        end
    end

endmodule

/* tb/keyed_parameter_cache_top_tb.sv */
// Testbench top for the keyed parameter cache: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module keyed_parameter_cache_top_tb;
    import kpc_pkg::*;

    localparam int POOL_SIZE      = ENTRIES + 8;
    localparam int POOL_W         = $clog2(POOL_SIZE);
    localparam int PHASE_ITEMS    = 175;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = ENTRIES + 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // request channel
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        req_cmd = CMD_WRITE;
    logic [7:0]  req_axis = '0;
    logic [15:0] req_index = '0;
    logic [7:0]  req_subindex = '0;
    logic [31:0] req_data = '0;

    // response channel
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [1:0]  rsp_status;
    logic [31:0] rsp_data;

    int fail_count;
    int pending;
    int checked;
    int read_hits;
    int evictions;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_rejected = 0;
    int quiet_cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    keyed_parameter_cache_top u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .o_stall           (req_stall),
        .i_cmd             (req_cmd),
        .i_axis_number     (req_axis),
        .i_object_index    (req_index),
        .i_object_subindex (req_subindex),
        .i_write_data      (req_data),
        .o_valid           (rsp_valid),
        .i_stall           (rsp_stall),
        .o_status          (rsp_status),
        .o_read_data       (rsp_data)
    );

    keyed_parameter_cache_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .i_stall_in        (req_stall),
        .i_cmd             (req_cmd),
        .i_axis_number     (req_axis),
        .i_object_index    (req_index),
        .i_object_subindex (req_subindex),
        .i_write_data      (req_data),
        .i_rsp_valid       (rsp_valid),
        .i_rsp_stall       (rsp_stall),
        .i_status          (rsp_status),
        .i_read_data       (rsp_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_read_hits       (read_hits),
        .o_evictions       (evictions)
    );

    // Stall the response side at random; the rate changes per phase.
    always @(negedge clk) begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run if no transfer happens on either channel for too long.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("FAIL keyed_parameter_cache_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request and hold it until the block takes the transfer.
    // Idle cycles go in front of it; a back-to-back request keeps valid high.
    task automatic drive_access(input logic cmd, input logic [7:0] axis,
                                input logic [15:0] index, input logic [7:0] sub,
                                input logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid    <= 1'b1;
        req_cmd      <= cmd;
        req_axis     <= axis;
        req_index    <= index;
        req_subindex <= sub;
        req_data     <= data;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (axis >= NUM_AXES) n_rejected++;
        else if (cmd == CMD_READ) n_reads++;
        else n_writes++;
    endtask

    // Random request: mostly pool keys on a couple of busy axes so that banks
    // fill up, hit often and get their entry 0 replaced; some absent axes and
    // fully random keys as noise.
    task automatic random_access();
        logic              cmd;
        logic [7:0]        axis;
        logic [KEY_W-1:0]  key;
        logic [POOL_W-1:0] pool_sel;
        int                pick;
        cmd  = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 8) axis = 8'($urandom_range(255, NUM_AXES));
        else if (pick < 55) axis = 8'($urandom_range(1, 0));
        else axis = 8'($urandom_range(NUM_AXES - 1, 0));
        pool_sel = POOL_W'($urandom_range(POOL_SIZE - 1, 0));
        if ($urandom_range(99) < 85) key = key_pool[pool_sel];
        else key = KEY_W'($urandom);
        drive_access(cmd, axis, key[23:8], key[7:0], $urandom);
    endtask

    initial begin
        logic [15:0] fill_index [ENTRIES];
        logic [7:0]  fill_sub   [ENTRIES];
        int          mid;
        mid = ENTRIES / 2;

        for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = KEY_W'($urandom);
        // first key all zeros, last key all ones, middle keys distinct by subindex
        for (int e = 0; e < ENTRIES; e++) begin
            fill_index[e] = 16'($urandom);
            fill_sub[e]   = e[7:0];
        end
        fill_index[0]           = 16'h0000;
        fill_sub[0]             = 8'h00;
        fill_index[ENTRIES - 1] = 16'hFFFF;
        fill_sub[ENTRIES - 1]   = 8'hFF;

        // hold reset, then release it at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 26;
        recv_stall_pct = 55;

        // Directed: fill bank 0, extreme data on the first and last entries.
        for (int e = 0; e < ENTRIES; e++) begin
            drive_access(CMD_WRITE, 8'd0, fill_index[e], fill_sub[e],
                         (e == 0) ? 32'h0 : (e == ENTRIES - 1) ? 32'hFFFF_FFFF : $urandom);
        end
        // update an existing key in place
        drive_access(CMD_WRITE, 8'd0, fill_index[mid], fill_sub[mid], 32'h5A5A_A5A5);
        // new key into a full bank replaces entry 0
        drive_access(CMD_WRITE, 8'd0, 16'hA5A5, 8'hC3, 32'hDEAD_BEEF);
        drive_access(CMD_READ, 8'd0, 16'hA5A5, 8'hC3, 32'hFFFF_FFFF);
        drive_access(CMD_READ, 8'd0, fill_index[0], fill_sub[0], 32'h0);
        drive_access(CMD_READ, 8'd0, fill_index[mid], fill_sub[mid], 32'h0);
        drive_access(CMD_READ, 8'd0, fill_index[ENTRIES - 1], fill_sub[ENTRIES - 1], 32'h0);
        // absent axes, write and read
        drive_access(CMD_WRITE, 8'(NUM_AXES), 16'h1234, 8'h56, 32'hFFFF_FFFF);
        drive_access(CMD_READ, 8'd255, 16'hFFFF, 8'hFF, 32'h0);
        // miss on an empty bank, then a hit whose value is zero
        drive_access(CMD_READ, 8'(NUM_AXES - 1), 16'hFFFF, 8'hFF, 32'h0);
        drive_access(CMD_WRITE, 8'(NUM_AXES - 1), 16'hFFFF, 8'hFF, 32'h0);
        drive_access(CMD_READ, 8'(NUM_AXES - 1), 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);

        // Random phases: sender-light/receiver-heavy, swapped, then no idling.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 26 : (ph == 1) ? 55 : 0;
            recv_stall_pct = (ph == 0) ? 55 : (ph == 1) ? 26 : 0;
            repeat (PHASE_ITEMS) random_access();
        end

        // drop valid, drain the outstanding results, then watch for strays
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d writes, %0d reads and %0d requests to absent axes",
                 n_writes, n_reads, n_rejected);
        $display("%0d results checked, %0d read hits, %0d full-bank replacements of entry 0",
                 checked, read_hits, evictions);
        if (fail_count == 0) begin
            $display("PASS keyed_parameter_cache_top");
        end else begin
            $display("FAIL keyed_parameter_cache_top");
        end
        $finish;
    end

endmodule
